[rtl/esc_pkg.sv]
package esc_pkg;

  localparam logic [11:0] BaseYear  = 12'd1970;
  localparam logic [16:0] OffsetRst = 17'd28800;

  // floor(2^32 / d): the product's upper word is the quotient or one below it
  localparam logic [27:0] Recip60 = 28'd71582788;
  localparam logic [27:0] Recip24 = 28'd178956970;

  typedef enum logic [1:0] {
    DIV_SEC,
    DIV_MIN,
    DIV_HOUR
  } div_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_FIX,
    S_YEAR,
    S_MONTH
  } state_e;

  typedef struct packed {
    logic     load;
    logic     mul;
    logic     fix;
    div_sel_e sel;
    logic     year_step;
    logic     month_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } sts_t;

  // years reachable from a 32-bit count are 1970..2106, where 2100 is the only
  // multiple of four that is not a leap year
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != 12'd2100);
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:                      len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/esc_ctrl.sv]
module esc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output esc_pkg::cmd_t cmd_o,
  input  esc_pkg::sts_t sts_i
);
  import esc_pkg::*;

  state_e   state_q, state_d;
  div_sel_e sel_q, sel_d;
  logic     out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sel_q       <= DIV_SEC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sel_d      = sel_q;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    s_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          sel_d      = DIV_SEC;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        case (sel_q)
          DIV_SEC: begin
            sel_d   = DIV_MIN;
            state_d = S_MUL;
          end
          DIV_MIN: begin
            sel_d   = DIV_HOUR;
            state_d = S_MUL;
          end
          default: state_d = S_YEAR;
        endcase
      end
      S_YEAR: begin
        if (sts_i.year_more) cmd_o.year_step = 1'b1;
        else state_d = S_MONTH;
      end
      S_MONTH: begin
        if (sts_i.month_more) begin
          cmd_o.month_step = 1'b1;
        end else if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  assign m_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_ready_i))
    else $error("result register overwritten");
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!sts_i.month_more && state_q == S_MONTH))
    else $error("result loaded before month walk finished");
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_valid_i && s_ready_o) |=> (state_q == S_MUL && sel_q == DIV_SEC))
    else $error("accepted transfer did not start conversion");
`endif

endmodule

[rtl/esc_dp.sv]
module esc_dp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [16:0]   cfg_data_i,
  input  logic [31:0]   epoch_i,
  input  esc_pkg::cmd_t cmd_i,
  output esc_pkg::sts_t sts_o,
  output logic [39:0]   result_o
);
  import esc_pkg::*;

  logic [16:0] offset_q;
  logic [31:0] x_q;
  logic [59:0] prod_q;
  logic [5:0]  sec_q, min_q;
  logic [4:0]  hour_q;
  logic [15:0] days_q;
  logic [11:0] year_q;
  logic [3:0]  mon_q;
  logic [39:0] out_q;

  logic signed [33:0] sum;
  logic [31:0] clamped;
  logic [27:0] recip, quot, quot_fix;
  logic [5:0]  divisor, rem_fix;
  logic [31:0] qd, rem;
  logic        rem_ge;
  logic        leap;
  logic [8:0]  year_len;
  logic [4:0]  mlen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) offset_q <= OffsetRst;
    else if (cfg_we_i) offset_q <= cfg_data_i;
  end

  // epoch plus signed offset, clamped to the unsigned 32-bit range
  assign sum = $signed({2'b00, epoch_i}) + $signed({{17{offset_q[16]}}, offset_q});
  always_comb begin
    if (sum[33]) clamped = '0;
    else if (sum[32]) clamped = '1;
    else clamped = sum[31:0];
  end

  always_comb begin
    case (cmd_i.sel)
      DIV_HOUR: begin
        recip   = Recip24;
        divisor = 6'd24;
      end
      default: begin
        recip   = Recip60;
        divisor = 6'd60;
      end
    endcase
  end

  assign quot     = prod_q[59:32];
  assign qd       = {4'b0, quot} * {26'b0, divisor};
  assign rem      = x_q - qd;
  assign rem_ge   = rem[6:0] >= {1'b0, divisor};
  assign rem_fix  = rem_ge ? rem[5:0] - divisor : rem[5:0];
  assign quot_fix = rem_ge ? quot + 28'd1 : quot;

  assign leap     = is_leap(year_q);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mlen     = month_len(leap, mon_q);

  assign sts_o.year_more  = days_q >= {7'b0, year_len};
  assign sts_o.month_more = (mon_q < 4'd11) && (days_q >= {11'b0, mlen});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= clamped;
      year_q <= BaseYear;
      mon_q  <= '0;
    end
    if (cmd_i.mul) prod_q <= {28'b0, x_q} * {32'b0, recip};
    if (cmd_i.fix) begin
      case (cmd_i.sel)
        DIV_SEC: begin
          sec_q <= rem_fix;
          x_q   <= {4'b0, quot_fix};
        end
        DIV_MIN: begin
          min_q <= rem_fix;
          x_q   <= {4'b0, quot_fix};
        end
        default: begin
          hour_q <= rem_fix[4:0];
          days_q <= quot_fix[15:0];
        end
      endcase
    end
    if (cmd_i.year_step) begin
      days_q <= days_q - {7'b0, year_len};
      year_q <= year_q + 12'd1;
    end
    if (cmd_i.month_step) begin
      days_q <= days_q - {11'b0, mlen};
      mon_q  <= mon_q + 4'd1;
    end
    if (cmd_i.out_load) begin
      out_q <= {2'b00, sec_q, min_q, hour_q, days_q[4:0] + 5'd1, mon_q + 4'd1, year_q};
    end
  end

  assign result_o = out_q;

endmodule

[rtl/epoch_seconds_to_calendar.sv]
// Seconds-since-1970 to Gregorian calendar converter.
// Input stream: one 32-bit epoch count per transfer on s_axis. The zone offset
// register (17-bit two's complement seconds, written over cfg_valid/cfg_data)
// is added first and the sum is clamped to 0 .. 2^32-1.
// Output stream: one result per input on m_axis, fields from bit 0 up: year,
// month (1..12), day (1..31), hour, minute, second.
// Steps: accept, three divisions by 60, 60 and 24 (a shared reciprocal
// multiplier, a multiply and a fix step each), one step per whole year
// removed (up to 136), one per whole month (up to 11), then the output
// register load, which waits while the previous result is still held.
// One item is converted at a time; s_axis_tready is high only while idle.
// The finished result sits in an output register, so the next item is taken
// while the previous result still waits on a stalled receiver; if a newer
// result is ready before the old one is taken, the converter holds it.
// Reset clears the control state, empties the output and sets the zone offset to 28800
// seconds. Configuration is always ready; the user writes it only while idle (unchecked).
module epoch_seconds_to_calendar (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i,     // zone_offset_seconds
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i, // epoch_seconds
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o  // year, month, day, hour, minute, second_of_minute
);
  import esc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  esc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  esc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .epoch_i    (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .result_o   (m_axis_tdata_o)
  );

endmodule

[bench/epoch_seconds_to_calendar_tb.sv]
module epoch_seconds_to_calendar_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::OffsetRst;

  localparam int StallLimit   = 5000;
  localparam int HoldCycles   = 400;
  localparam int HoldAt       = 200;
  localparam int SettleCycles = 200;
  localparam int Phases       = 8;
  localparam int RandPerPhase = 125;
  localparam logic [31:0] EpochMax = 32'hFFFF_FFFF;

  // result fields, highest first so that year lands in the low bits
  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_t;

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // seconds from the epoch to a day of year and second of day
  function automatic longint epoch_of(input int y, input int doy, input int secs);
    longint days;
    int k;
    days = doy;
    for (k = 1970; k < y; k++) days += leap_year(k) ? 366 : 365;
    return days * 86400 + secs;
  endfunction

  class calendar_board;
    calendar_t          dates_due[$];
    logic signed [16:0] zone_offset;
    int                 errors;

    function new();
      zone_offset = OffsetRst;
      errors      = 0;
    endfunction

    function void set_offset(input logic [16:0] v);
      zone_offset = v;
    endfunction

    function calendar_t to_calendar(input logic [31:0] e);
      calendar_t   c;
      longint      sum;
      int unsigned t;
      int unsigned days;
      int          y;
      int          m;
      bit          leap;
      int          mlen[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      sum = longint'(e) + longint'(zone_offset);
      if (sum < 0) sum = 0;
      if (sum > longint'(EpochMax)) sum = longint'(EpochMax);
      t = sum[31:0];
      c.sec = 6'(t % 60);
      t = t / 60;
      c.minute = 6'(t % 60);
      t = t / 60;
      c.hour = 5'(t % 24);
      days = t / 24;
      y = 1970;
      leap = leap_year(y);
      while (days >= (leap ? 366 : 365)) begin
        days -= leap ? 366 : 365;
        y++;
        leap = leap_year(y);
      end
      if (leap) mlen[1] = 29;
      m = 0;
      while (m < 11 && days >= mlen[m]) begin
        days -= mlen[m];
        m++;
      end
      c.year  = 12'(y);
      c.month = 4'(m + 1);
      c.day   = 5'(days + 1);
      return c;
    endfunction

    function void note_epoch(input logic [31:0] e);
      dates_due.push_back(to_calendar(e));
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input logic [39:0] tdata);
      calendar_t got;
      calendar_t want;
      if (dates_due.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing pending", tdata));
      end else begin
        got  = tdata[37:0];
        want = dates_due.pop_front();
        if (tdata[39:38] != 2'b00)
          report_mismatch($sformatf("padding bits %b", tdata[39:38]));
        if (got.year != want.year)
          report_mismatch($sformatf("year %0d, want %0d", got.year, want.year));
        if (got.month != want.month)
          report_mismatch($sformatf("month %0d, want %0d", got.month, want.month));
        if (got.day != want.day)
          report_mismatch($sformatf("day %0d, want %0d", got.day, want.day));
        if (got.hour != want.hour)
          report_mismatch($sformatf("hour %0d, want %0d", got.hour, want.hour));
        if (got.minute != want.minute)
          report_mismatch($sformatf("minute %0d, want %0d", got.minute, want.minute));
        if (got.sec != want.sec)
          report_mismatch($sformatf("second %0d, want %0d", got.sec, want.sec));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [16:0] cfg_data;
  logic        s_valid;
  logic        s_ready;
  logic [31:0] s_data;
  logic        m_valid;
  logic        m_ready;
  logic [39:0] m_data;

  calendar_board board = new();
  int          epochs_sent = 0;
  bit          steady = 1'b0;
  bit          hold_done = 1'b0;
  int          quiet_cycles = 0;

  epoch_seconds_to_calendar dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task send_epoch(input logic [31:0] e);
    int gap;
    gap = (!steady && $urandom_range(99) < 36) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= e;
    do @(posedge clk_i); while (!s_ready);
    board.note_epoch(e);
    epochs_sent++;
    @(negedge clk_i);
  endtask

  task write_zone(input logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    board.set_offset(v);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task wait_drained();
    s_valid <= 1'b0;
    while (board.dates_due.size() != 0) @(negedge clk_i);
  endtask

  // receiver: random backpressure plus one long hold so the converter fills up
  initial begin
    m_ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && epochs_sent >= HoldAt) begin
        hold_done = 1'b1;
        m_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      m_ready <= steady || ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) board.check_result(m_data);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("epoch_seconds_to_calendar_tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [16:0] zone_plan[Phases];
    logic [31:0] picks[$];
    longint      target;
    int          y;
    int          p;
    int          i;
    zone_plan = '{17'd0, -17'sd50400, 17'd50400, 17'h10000, 17'h0FFFF, 17'd28800,
                  17'd0, 17'd0};
    zone_plan[6] = 17'($urandom_range(0, 17'h1FFFF));
    zone_plan[7] = 17'($urandom_range(0, 17'h1FFFF));
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_valid   = 1'b0;
    s_data    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (p = 0; p < Phases; p++) begin
      wait_drained();
      write_zone(zone_plan[p]);
      picks.delete();
      case (p)
        0: picks = '{32'd0, 32'd59, 32'd60, 32'd86399, 32'd86400,
                     32'(epoch_of(1972, 59, 0)), 32'(epoch_of(1972, 365, 86399)),
                     32'(epoch_of(2000, 59, 43200)), 32'(epoch_of(2000, 365, 86399)),
                     32'(epoch_of(2100, 58, 86399)), 32'(epoch_of(2100, 59, 0)),
                     32'(epoch_of(2106, 0, 0)), EpochMax};
        // negative offsets: clamp to zero and the edge around it
        1: picks = '{32'd0, 32'd50399, 32'd50400, 32'd50401};
        3: picks = '{32'd0, 32'd65535, 32'd65536};
        // positive offsets: clamp at the top
        2: picks = '{EpochMax, EpochMax - 32'd50400, EpochMax - 32'd50399};
        4: picks = '{EpochMax, EpochMax - 32'd65535, EpochMax - 32'd65536};
        default: ;
      endcase
      foreach (picks[k]) send_epoch(picks[k]);

      steady = (p == 5);
      for (i = 0; i < RandPerPhase; i++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: send_epoch($urandom);
          5, 6, 7: begin
            // around new year and the end of february, shifted back by the offset
            y = $urandom_range(1970, 2106);
            target = epoch_of(y, $urandom_range(1) ? 0 : 59, 0)
                     + longint'($urandom_range(0, 4 * 86400)) - 2 * 86400
                     - longint'(board.zone_offset);
            if (target < 0) target = 0;
            if (target > longint'(EpochMax)) target = longint'(EpochMax);
            send_epoch(target[31:0]);
          end
          8: send_epoch($urandom_range(0, 100000));
          default: send_epoch(EpochMax - $urandom_range(0, 100000));
        endcase
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.dates_due.size() != 0)
      board.report_mismatch($sformatf("%0d results never came", board.dates_due.size()));
    if (board.errors == 0)
      $display("epoch_seconds_to_calendar_tb passed");
    else
      $display("epoch_seconds_to_calendar_tb failed");
    $finish;
  end

endmodule

[files.f]
rtl/esc_pkg.sv
rtl/esc_ctrl.sv
rtl/esc_dp.sv
rtl/epoch_seconds_to_calendar.sv
bench/epoch_seconds_to_calendar_tb.sv
